// ===== hw/rtl/plist_pkg.sv =====
// ----------------------------------------------------------------------------
// plist_pkg: shared types and constants for the positional list
// Capacity, field widths, command and status codes, cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package plist_pkg;

  // Number of cells in the chain (range 2 to 31)
  localparam int CAPACITY = 16;

  // Occupancy needs to hold CAPACITY itself
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = $clog2(CAPACITY);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Packed word widths, padded to whole bytes
  localparam int IN_FIELDS_W  = CMD_W + INDEX_W + VALUE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + COUNT_W + VALUE_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cell load select; all clear means hold
  typedef struct packed {
    logic take_new;    // load the inserted word
    logic take_left;   // shift up from the lower neighbor
    logic take_right;  // shift down from the upper neighbor
    logic take_head;   // wrap the head word around during a dump
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plist_cell.sv =====
// ----------------------------------------------------------------------------
// plist_cell: one storage cell of the list chain
// Holds one word and loads from its neighbors, the new word or the head.
// ----------------------------------------------------------------------------
`default_nettype none

module plist_cell
  import plist_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic [VALUE_W-1:0] new_i,
  input  wire logic [VALUE_W-1:0] left_i,
  input  wire logic [VALUE_W-1:0] right_i,
  input  wire logic [VALUE_W-1:0] head_i,
  output logic      [VALUE_W-1:0] data_o
);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;

  // Select the next word; the controls are mutually exclusive
  always_comb begin
    priority if (ctl.take_new) begin
      data_nxt = new_i;
    end else if (ctl.take_left) begin
      data_nxt = left_i;
    end else if (ctl.take_right) begin
      data_nxt = right_i;
    end else if (ctl.take_head) begin
      data_nxt = head_i;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with insert, delete and dump
// A chain of cells holds the list; insert and delete shift the cells from
// the given position up, and a dump rotates the occupied cells past the head.
// ----------------------------------------------------------------------------
//
//  Port group  Dir  tdata fields (low bit up)            tuser       tlast
//  in_*        in   cmd[1:0] index[9:2] value[41:10]     -           -
//  out_*       out  status[1:0] count[6:2] elem[38:7]    elem_valid  last
//
//  Insert, delete and unused commands each give one word.
//  A dump of n entries holds in_tready low while it runs and gives n words:
//  the first once the list has entered the dump state, then one per cycle
//  while out_tready is high, paced by the chain rotation; an empty dump
//  gives one word and does not enter the dump state.
//  The output register lets a new command enter in the cycle its word is
//  taken. A held word with out_tready low stalls dumps and new commands.
//  rst_n (synchronous, active low) empties the list; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete
  import plist_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // cmd, index, value
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // status, count, elem_value
  output logic [0:0]                 out_tuser,  // elem_valid
  output logic                       out_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [POS_W-1:0]    dcnt_r, dcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [VALUE_W-1:0]  elem_r, elem_nxt;
  logic                evalid_r, evalid_nxt;
  logic                last_r, last_nxt;

  logic [CMD_W-1:0]    cmd;
  logic [INDEX_W-1:0]  index;
  logic [VALUE_W-1:0]  value;
  logic                neg;
  logic [7:0]          pos8;
  logic [7:0]          occ8;
  logic                slot_free;
  logic                acc;
  logic                ins_ok;
  logic                del_ok;
  logic                rot;
  logic                dump_last;

  logic [VALUE_W-1:0]  cell_q [CAPACITY];
  cell_ctl_t           cell_ctl [CAPACITY];

  // Unpack the input word
  assign cmd   = in_tdata[CMD_W-1:0];
  assign index = in_tdata[CMD_W +: INDEX_W];
  assign value = in_tdata[CMD_W+INDEX_W +: VALUE_W];
  assign neg   = index[INDEX_W-1];
  assign pos8  = {1'b0, index[INDEX_W-2:0]};
  assign occ8  = 8'(occ_r);

  // Handshake
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign acc       = in_tvalid && in_tready;

  // Qualify chain updates
  assign ins_ok = acc && (cmd == CMD_INSERT) && !neg && (pos8 <= occ8)
                  && (occ8 != 8'(CAPACITY));
  assign del_ok = acc && (cmd == CMD_DELETE) && !neg && (pos8 < occ8);
  assign rot    = (state_r == S_DUMP) && slot_free;
  assign dump_last = (8'(dcnt_r) + 8'd1) == occ8;

  // Build the cell chain and its load selects
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [7:0] CI  = 8'(i);
    localparam logic [7:0] CI1 = 8'(i + 1);
    logic [VALUE_W-1:0] left_w;
    logic [VALUE_W-1:0] right_w;

    if (i == 0) begin : g_lo
      assign left_w = value;
    end else begin : g_lo
      assign left_w = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi
      assign right_w = '0;
    end else begin : g_hi
      assign right_w = cell_q[i+1];
    end

    always_comb begin
      cell_ctl[i].take_new   = ins_ok && (CI == pos8);
      cell_ctl[i].take_left  = ins_ok && (CI > pos8) && (CI <= occ8);
      cell_ctl[i].take_right = (del_ok && (CI >= pos8) && (CI1 < occ8))
                               || (rot && (CI1 < occ8));
      cell_ctl[i].take_head  = rot && (CI1 == occ8);
    end

    plist_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[i]),
      .new_i   (value),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_q[0]),
      .data_o  (cell_q[i])
    );
  end

  // Command sequencing and result register
  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    count_nxt     = count_r;
    elem_nxt      = elem_r;
    evalid_nxt    = evalid_r;
    last_nxt      = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          status_nxt    = ST_OK;
          elem_nxt      = '0;
          evalid_nxt    = 1'b0;
          last_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          unique case (cmd)
            CMD_INSERT: begin
              if (neg || (pos8 > occ8)) begin
                status_nxt = ST_RANGE;
              end else if (occ8 == 8'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            CMD_DELETE: begin
              if (neg || (pos8 >= occ8)) begin
                status_nxt = ST_RANGE;
              end else begin
                occ_nxt = occ_r - OCC_W'(1);
              end
            end
            CMD_DUMP: begin
              if (occ_r != '0) begin
                out_valid_nxt = 1'b0;
                dcnt_nxt      = '0;
                state_nxt     = S_DUMP;
              end
            end
            default: begin
              // unused code: report current count only
            end
          endcase
          count_nxt = COUNT_W'(occ_nxt);
        end
      end
      S_DUMP: begin
        if (rot) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          count_nxt     = COUNT_W'(occ_r);
          elem_nxt      = cell_q[0];
          evalid_nxt    = 1'b1;
          last_nxt      = dump_last;
          dcnt_nxt      = dcnt_r + POS_W'(1);
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    count_r  <= count_nxt;
    elem_r   <= elem_nxt;
    evalid_r <= evalid_nxt;
    last_r   <= last_nxt;
  end

  // Drive the result word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({elem_r, count_r, status_r});
  assign out_tuser  = evalid_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire
